// File: hdl/u8d_pkg.sv
// Shared types, constants and the lead byte classifier for the UTF-8 decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

   // Byte class masks and patterns
   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_PAT  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_PAT  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_PAT  = 8'hF0;

   // Sequence lengths a lead byte can announce
   localparam logic [2:0] LEN_SKIP  = 3'd0;
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   localparam int CP_W = 21;

   // Result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            has_point;
      logic            end_of_string;
      logic            last_of_run;
   } result_type;

   // Results produced by one byte, count is 0 when nothing moves
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } pair_type;

   function automatic logic [2:0] lead_length(input logic [7:0] c);
      logic [2:0] len;
      if ((c & ASCII_MASK) == 8'h00) begin
         len = LEN_ONE;
      end else if ((c & LEAD2_MASK) == LEAD2_PAT) begin
         len = LEN_TWO;
      end else if ((c & LEAD3_MASK) == LEAD3_PAT) begin
         len = LEN_THREE;
      end else if ((c & LEAD4_MASK) == LEAD4_PAT) begin
         len = LEN_FOUR;
      end else begin
         len = LEN_SKIP;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// File: hdl/u8d_req_if.sv
// Byte input channel interface.
`timescale 1ns / 1ps
`default_nettype none

interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       final_byte;

   modport source (output valid, output byte_value, output final_byte, input ready);
   modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/u8d_rsp_if.sv
// Code point result channel interface.
`timescale 1ns / 1ps
`default_nettype none

interface u8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        has_point;
   logic        end_of_string;
   logic        last_of_run;

   modport source (output valid, output code_point, output has_point,
                   output end_of_string, output last_of_run, input ready);
   modport sink   (input valid, input code_point, input has_point,
                   input end_of_string, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hdl/utf8_lenient_decoder_unit.sv
// Each accepted byte is registered in the input stage, then decoded into the result queue.
// Throughput: one byte per cycle while the four-entry result queue has two free slots; a byte
// giving two code points pushes both into that queue, which drains them one at a time.
// Reset: synchronous, active high; clears decode state, the input stage and the queue.
// Held continuation bytes and queue entries are not reset.
`timescale 1ns / 1ps
`default_nettype none

module utf8_lenient_decoder_unit (
   input  logic     clock,
   input  logic     reset,
   u8d_req_if.sink  req_ch,
   u8d_rsp_if.source rsp_ch
);
   import u8d_pkg::*;

   pair_type   pair;
   logic       room;
   result_type head;

   u8d_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_byte    (req_ch.byte_value),
      .in_final   (req_ch.final_byte),
      .queue_room (room),
      .pair       (pair)
   );

   u8d_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (head)
   );

   // Result channel payload
   assign rsp_ch.code_point    = head.code_point;
   assign rsp_ch.has_point     = head.has_point;
   assign rsp_ch.end_of_string = head.end_of_string;
   assign rsp_ch.last_of_run   = head.last_of_run;

`ifndef SYNTH
   // queue is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   // a pair always carries two real points and only the second closes the run
   a_pair_shape: assert property (@(posedge clock) disable iff (reset)
      (pair.count == 2'd2) |-> (pair.first.has_point && pair.second.has_point &&
                               !pair.first.last_of_run && pair.second.last_of_run))
      else $error("malformed two-result push");

   // an empty result only closes a string
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (pair.count != 2'd0 && !pair.first.has_point) |->
         (pair.first.end_of_string && pair.count == 2'd1 && pair.first.code_point == '0))
      else $error("empty result outside end of string");

   // never push while the queue lacks room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (pair.count != 2'd0) |-> room)
      else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

// File: hdl/u8d_decoder.sv
// Input register, decode state and single-pass byte decode.
`timescale 1ns / 1ps
`default_nettype none

module u8d_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_final,
   input  logic              queue_room,
   output u8d_pkg::pair_type pair
);
   import u8d_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      byte_ff;
   logic            fin_ff;
   logic [1:0]      need_ff, need_in;
   logic [1:0]      coll_ff, coll_in;
   logic [CP_W-1:0] acc_ff, acc_in;
   logic [7:0]      held_ff, held_in;

   logic            accept, move;
   logic [2:0]      lead_b, lead_h;
   logic [CP_W-1:0] cand0, cand1;
   logic            v0, v1;
   logic [1:0]      cnt;
   result_type      r0, r1;

   assign move     = in_valid_ff && queue_room;
   assign in_ready = !in_valid_ff || move;
   assign accept   = in_valid && in_ready;

   // Next decode state and candidate code points
   always_comb begin
      lead_b  = lead_length(byte_ff);
      lead_h  = lead_length(held_ff);
      cand0   = '0;
      cand1   = '0;
      need_in = need_ff;
      coll_in = coll_ff;
      acc_in  = acc_ff;
      held_in = held_ff;
      if (need_ff != 2'd0) begin
         if (need_ff == 2'd1) begin
            // last continuation completes the sequence
            cand0   = {acc_ff[CP_W-7:0], byte_ff[5:0]};
            need_in = 2'd0;
            coll_in = 2'd0;
            acc_in  = '0;
         end else if (fin_ff) begin
            // string ends inside a sequence: redecode the held tail
            if (coll_ff == 2'd0) begin
               if (lead_b == LEN_ONE) cand0 = {13'd0, byte_ff};
            end else if (lead_h == LEN_ONE) begin
               cand0 = {13'd0, held_ff};
               if (lead_b == LEN_ONE) cand1 = {13'd0, byte_ff};
            end else if (lead_h == LEN_TWO) begin
               cand0 = {10'd0, held_ff[4:0], byte_ff[5:0]};
            end else if (lead_b == LEN_ONE) begin
               cand0 = {13'd0, byte_ff};
            end
         end else begin
            // only the first held byte is ever redecoded
            if (!coll_ff[0]) held_in = byte_ff;
            acc_in  = {acc_ff[CP_W-7:0], byte_ff[5:0]};
            need_in = need_ff - 2'd1;
            coll_in = coll_ff + 2'd1;
         end
      end else begin
         if (lead_b == LEN_ONE) begin
            cand0 = {13'd0, byte_ff};
         end else if (lead_b != LEN_SKIP && !fin_ff) begin
            case (lead_b)
               LEN_TWO:   acc_in = {16'd0, byte_ff[4:0]};
               LEN_THREE: acc_in = {17'd0, byte_ff[3:0]};
               default:   acc_in = {18'd0, byte_ff[2:0]};
            endcase
            need_in = 2'(lead_b - 3'd1);
            coll_in = 2'd0;
         end
      end
      if (fin_ff) begin
         need_in = 2'd0;
         coll_in = 2'd0;
         acc_in  = '0;
      end
   end

   // Drop zero points and pack results
   always_comb begin
      v0 = (cand0 != '0);
      v1 = (cand1 != '0);
      r0 = '0;
      r1 = '0;
      cnt = 2'd0;
      if (v0 && v1) begin
         cnt = 2'd2;
         r0  = '{code_point: cand0, has_point: 1'b1, end_of_string: 1'b0, last_of_run: 1'b0};
         r1  = '{code_point: cand1, has_point: 1'b1, end_of_string: fin_ff,
                 last_of_run: 1'b1};
      end else if (v0 || v1) begin
         cnt = 2'd1;
         r0  = '{code_point: (v0 ? cand0 : cand1), has_point: 1'b1,
                 end_of_string: fin_ff, last_of_run: 1'b1};
      end else if (fin_ff) begin
         // final byte without a point still closes the string
         cnt = 2'd1;
         r0  = '{code_point: '0, has_point: 1'b0, end_of_string: 1'b1, last_of_run: 1'b1};
      end
      pair.count  = move ? cnt : 2'd0;
      pair.first  = r0;
      pair.second = r1;
   end

   // Input stage and state registers
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         need_ff     <= 2'd0;
         coll_ff     <= 2'd0;
         acc_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (move) begin
            need_ff <= need_in;
            coll_ff <= coll_in;
            acc_ff  <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= in_byte;
         fin_ff  <= in_final;
      end
      if (move) held_ff <= held_in;
   end

endmodule

`default_nettype wire

// File: hdl/u8d_result_fifo.sv
// Small result queue taking up to two items per cycle and giving one.
`timescale 1ns / 1ps
`default_nettype none

module u8d_result_fifo (
   input  logic                clock,
   input  logic                reset,
   input  u8d_pkg::pair_type   pair,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output u8d_pkg::result_type out_item
);
   import u8d_pkg::*;

   result_type            mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;
   logic [FIFO_PTR_W-1:0] wr_next;

   assign room      = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem[rd_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = FIFO_PTR_W'(wr_ff + 1'b1);

   // Pointer and occupancy update
   always_comb begin
      wr_in    = FIFO_PTR_W'(wr_ff + pair.count);
      rd_in    = pop ? FIFO_PTR_W'(rd_ff + 1'b1) : rd_ff;
      count_in = FIFO_CNT_W'(count_ff + FIFO_CNT_W'(pair.count) - FIFO_CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Storage writes
   always_ff @(posedge clock) begin
      if (pair.count != 2'd0) mem[wr_ff] <= pair.first;
      if (pair.count == 2'd2) mem[wr_next] <= pair.second;
   end

endmodule

`default_nettype wire
